>>> design/vit_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vit_pkg
// Shared widths, codes, command and status types for the path metric scorer.
// ---------------------------------------------------------------------------
package vit_pkg;

	localparam int COST_W     = 24;
	localparam int ST_W       = 6;
	localparam int SYM_W      = 4;
	localparam int NUM_STATES = 64;
	localparam int CNT_W      = 7;
	localparam int TR_AW      = 2 * ST_W;
	localparam int EM_AW      = ST_W + SYM_W;
	localparam int PS_AW      = ST_W + 1;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_TRANS   = 2'd1;
	localparam logic [1:0] ACT_EMIT    = 2'd2;
	localparam logic [1:0] ACT_OBSERVE = 2'd3;

	typedef struct packed {
		logic clr;
		logic load;
		logic obs;
		logic row;
		logic wr;
		logic ord;
		logic out;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic s_act;
		logic s_last;
		logic r_last;
		logic first;
		logic last;
		logic out_last;
	} sts_t;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = (s >= {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
	endfunction

endpackage

>>> design/vit_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vit_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module vit_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/vit_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vit_ctrl
// Sequencer: clearing pass, loads, row recursion and score readout.
// ---------------------------------------------------------------------------
module vit_ctrl import vit_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ROW  = 3'd2;
	localparam logic [2:0] S_TAIL = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_ORD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (action == ACT_OBSERVE) begin
						cmd.obs = 1'b1;
						state_d = S_ROW;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_ROW: begin
				cmd.row = 1'b1;
				if (!sts.s_act || sts.first || sts.r_last) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_WR;
			S_WR: begin
				cmd.wr = 1'b1;
				if (!sts.s_last) state_d = S_ROW;
				else if (sts.last) state_d = S_ORD;
				else state_d = S_IDLE;
			end
			S_ORD: begin
				cmd.ord = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.out = 1'b1;
				state_d = sts.out_last ? S_IDLE : S_ORD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> design/vit_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vit_dp
// Cost tables, path score banks, add-compare-select accumulator and counters.
// ---------------------------------------------------------------------------
module vit_dp import vit_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic [ST_W-1:0]   target_state,
	input  logic [ST_W-1:0]   source_state,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [COST_W-1:0] cost,
	input  logic              first_obs,
	input  logic              last_obs,
	input  logic [1:0]        action,
	output logic [ST_W-1:0]   state_index,
	output logic [COST_W-1:0] score,
	output logic              last
);

	logic [CNT_W-1:0]  act_q, n_live;
	logic [ST_W-1:0]   n_m1;
	logic [TR_AW-1:0]  clr_q;
	logic [ST_W-1:0]   s_q, r_q;
	logic              bank_q, first_q, last_q, acc_v_s1;
	logic [SYM_W-1:0]  sym_q;
	logic [COST_W-1:0] acc_q, tr_rd, ps_rd, em_rd, st_rd, nxt;
	logic              tgt_ok, src_ok;

	always_comb begin
		if (act_q == '0) n_live = CNT_W'(1);
		else if (act_q > CNT_W'(NUM_STATES)) n_live = CNT_W'(NUM_STATES);
		else n_live = act_q;
	end
	assign n_m1   = ST_W'(n_live - CNT_W'(1));
	assign tgt_ok = ({1'b0, target_state} < n_live);
	assign src_ok = ({1'b0, source_state} < n_live);

	assign sts.clr_done = (clr_q == {TR_AW{1'b1}});
	assign sts.s_act    = ({1'b0, s_q} < n_live);
	assign sts.s_last   = (s_q == {ST_W{1'b1}});
	assign sts.r_last   = (r_q == n_m1);
	assign sts.first    = first_q;
	assign sts.last     = last_q;
	assign sts.out_last = (s_q == n_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= CNT_W'(NUM_STATES);
			clr_q    <= '0;
			s_q      <= '0;
			r_q      <= '0;
			bank_q   <= 1'b0;
			acc_v_s1 <= 1'b0;
		end else begin
			if (cfg_we) act_q <= cfg_data;
			if (cmd.clr) clr_q <= clr_q + TR_AW'(1);
			acc_v_s1 <= cmd.row && sts.s_act && !first_q;
			if (cmd.obs) begin
				s_q <= '0;
				r_q <= '0;
			end
			if (cmd.row) r_q <= r_q + ST_W'(1);
			if (cmd.wr) begin
				r_q <= '0;
				s_q <= s_q + ST_W'(1);
				if (sts.s_last) bank_q <= ~bank_q;
			end
			if (cmd.out) s_q <= s_q + ST_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.obs) begin
			sym_q   <= symbol;
			first_q <= first_obs;
			last_q  <= last_obs;
		end
		if (cmd.obs || cmd.wr) begin
			acc_q <= COST_MAX;
		end else if (acc_v_s1) begin
			if (sat_add(tr_rd, ps_rd) < acc_q) acc_q <= sat_add(tr_rd, ps_rd);
		end
	end

	assign nxt = !sts.s_act ? COST_MAX : sat_add(em_rd, first_q ? st_rd : acc_q);

	vit_ram #(.WIDTH(COST_W), .DEPTH(1 << TR_AW)) u_trans (
		.clk   (clk),
		.we    (cmd.clr || (cmd.load && action == ACT_TRANS && tgt_ok && src_ok)),
		.waddr (cmd.clr ? clr_q : {source_state, target_state}),
		.wdata (cmd.clr ? COST_MAX : cost),
		.re    (cmd.row),
		.raddr ({r_q, s_q}),
		.rdata (tr_rd)
	);

	vit_ram #(.WIDTH(COST_W), .DEPTH(1 << EM_AW)) u_emit (
		.clk   (clk),
		.we    (cmd.load && action == ACT_EMIT && tgt_ok),
		.waddr ({target_state, symbol}),
		.wdata (cost),
		.re    (cmd.row),
		.raddr ({s_q, sym_q}),
		.rdata (em_rd)
	);

	vit_ram #(.WIDTH(COST_W), .DEPTH(1 << ST_W)) u_start (
		.clk   (clk),
		.we    (cmd.load && action == ACT_START && tgt_ok),
		.waddr (target_state),
		.wdata (cost),
		.re    (cmd.row),
		.raddr (s_q),
		.rdata (st_rd)
	);

	vit_ram #(.WIDTH(COST_W), .DEPTH(1 << PS_AW)) u_path (
		.clk   (clk),
		.we    (cmd.clr || cmd.wr),
		.waddr (cmd.clr ? clr_q[PS_AW-1:0] : {~bank_q, s_q}),
		.wdata (cmd.clr ? COST_MAX : nxt),
		.re    (cmd.row || cmd.ord),
		.raddr (cmd.ord ? {bank_q, s_q} : {bank_q, r_q}),
		.rdata (ps_rd)
	);

	assign state_index = s_q;
	assign score       = ps_rd;
	assign last        = sts.out_last;

endmodule

>>> design/viterbi_min_plus_scorer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// viterbi_min_plus_scorer
// Min-plus Viterbi path metric scorer with loadable cost tables.
// ---------------------------------------------------------------------------
// channel   handshake            payload
// input     start / busy         action target_state source_state symbol cost
//                                first_obs last_obs
// config    cfg_valid/cfg_ready  cfg_data (active_states)
// result    valid strobe         state_index score last
//
// After reset a clearing pass sets the transition table and path scores to
// impossible; busy stays high meanwhile. A load leaves busy low. Each
// observation walks every state through row, tail and write steps, with
// add-compare-select over n active sources, one per cycle (none for an
// inactive state or a first observation); a last one reports all n scores.
// The receiver cannot stall: each result is valid for one cycle.
// ---------------------------------------------------------------------------
module viterbi_min_plus_scorer import vit_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [ST_W-1:0]   target_state,
	input  logic [ST_W-1:0]   source_state,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [COST_W-1:0] cost,
	input  logic              first_obs,
	input  logic              last_obs,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              valid,
	output logic [ST_W-1:0]   state_index,
	output logic [COST_W-1:0] score,
	output logic              last
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;
	assign valid     = cmd.out;

	vit_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	vit_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.target_state (target_state),
		.source_state (source_state),
		.symbol       (symbol),
		.cost         (cost),
		.first_obs    (first_obs),
		.last_obs     (last_obs),
		.action       (action),
		.state_index  (state_index),
		.score        (score),
		.last         (last)
	);

endmodule
